FILE: hdl/drr_pkg.sv
package drr_pkg;

	localparam int SCALE_W   = 6;
	localparam int S_DATA_W  = 200;
	localparam int M_DATA_W  = 104;
	localparam int M_USER_W  = 1;
	localparam int DIGIT_W   = 4;
	localparam int LIMB_W    = 16;
	localparam int CUR_W     = DIGIT_W + LIMB_W;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;

	// Reciprocal of ten, exact for every value of CUR_W bits.
	localparam logic [CUR_W-1:0] RECIP_TEN   = 20'hCCCCD;
	localparam int               RECIP_SHIFT = 23;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_ROUND = 4'b1000
	} state_t;

endpackage

FILE: hdl/decimal_rescale_round_half_even.sv
// Decimal mantissa rescale with round half to even.
//
// Slave channel (s_*): one item is a 192-bit unsigned mantissa and its decimal
// scale. Master channel (m_*): one item is the 96-bit reduced mantissa, the new
// scale and an overflow flag. An item moves when tvalid and tready are high.
//
// While the mantissa needs more than NARROW_BITS bits and the scale is above
// zero, the mantissa is divided by ten and the scale lowered by one. A single
// reciprocal-multiply unit divides one 16-bit limb by ten per cycle, from the
// top limb down; each division then passes through a rounding state and back to
// the check state. The next item is accepted once the result has moved to the
// output register. At the default widths at most about 30 divisions are needed.
//
// One item is worked on at a time; s_tready is high only while the block is
// idle. The result sits in an output register, so a new item may be accepted
// while it waits; if the receiver stalls, the next result is held back in the
// check state until the register is free. Reset empties the block and drops any
// waiting result.
module decimal_rescale_round_half_even #(
	parameter int WIDE_BITS   = 192,
	parameter int NARROW_BITS = 96
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mantissa_low, mantissa_mid, mantissa_high, scale_in, zero pad
	input  logic [drr_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_low, result_high, scale_out, zero pad
	output logic [drr_pkg::M_DATA_W-1:0]  m_tdata,
	// overflow
	output logic [drr_pkg::M_USER_W-1:0]  m_tuser
);

	localparam int LIMB_W   = drr_pkg::LIMB_W;
	localparam int CUR_W    = drr_pkg::CUR_W;
	localparam int DIGIT_W  = drr_pkg::DIGIT_W;
	localparam int PROD_W   = 2 * CUR_W;
	localparam int PAD_BITS = ((WIDE_BITS + LIMB_W - 1) / LIMB_W) * LIMB_W;
	localparam int LIMBS    = PAD_BITS / LIMB_W;
	localparam int CNT_W    = (LIMBS > 1) ? $clog2(LIMBS) : 1;

	drr_pkg::state_t                    state_q;
	logic [PAD_BITS-1:0]                v_q;
	logic [drr_pkg::SCALE_W-1:0]        scale_q;
	logic [drr_pkg::DIGIT_W-1:0]        rem_q;
	logic                               sticky_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic                               m_tvalid_q;
	logic [drr_pkg::M_DATA_W-1:0]       m_tdata_q;
	logic [drr_pkg::M_USER_W-1:0]       m_tuser_q;

	logic                               wide;
	logic                               out_free;
	logic                               emit;
	logic                               round_up;
	logic [CUR_W-1:0]                   cur;
	logic [LIMB_W-1:0]                  q_limb;
	logic [CUR_W-1:0]                   q_times_ten;
	logic [drr_pkg::DIGIT_W-1:0]        rem_next;
	logic [PAD_BITS-1:0]                v_load;

	// The running remainder and the next limb, divided by ten.
	assign cur         = {rem_q, v_q[PAD_BITS-1 -: LIMB_W]};
	assign q_limb      = LIMB_W'((PROD_W'(cur) * PROD_W'(drr_pkg::RECIP_TEN))
		>> drr_pkg::RECIP_SHIFT);
	assign q_times_ten = CUR_W'({q_limb, 3'b000}) + CUR_W'({q_limb, 1'b0});
	assign rem_next    = DIGIT_W'(cur - q_times_ten);

	assign wide     = |v_q[PAD_BITS-1:NARROW_BITS];
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (state_q == drr_pkg::ST_CHECK) && !(wide && scale_q != '0) && out_free;
	assign v_load   = PAD_BITS'(s_tdata[WIDE_BITS-1:0]);

	// The digit just dropped decides; a tie goes up when an earlier digit was
	// nonzero, otherwise to the even neighbour.
	always_comb begin
		if (rem_q > drr_pkg::DIGIT_HALF) begin
			round_up = 1'b1;
		end else if (rem_q == drr_pkg::DIGIT_HALF) begin
			round_up = sticky_q || v_q[0];
		end else begin
			round_up = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= drr_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				drr_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= drr_pkg::ST_CHECK;
					end
				end
				drr_pkg::ST_CHECK: begin
					if (wide && scale_q != '0) begin
						state_q <= drr_pkg::ST_DIV;
					end else if (out_free) begin
						state_q <= drr_pkg::ST_IDLE;
					end
				end
				drr_pkg::ST_DIV: begin
					if (cnt_q == CNT_W'(LIMBS - 1)) begin
						state_q <= drr_pkg::ST_ROUND;
					end
				end
				drr_pkg::ST_ROUND: begin
					state_q <= drr_pkg::ST_CHECK;
				end
				default: begin
					state_q <= drr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			drr_pkg::ST_IDLE: begin
				v_q      <= v_load;
				scale_q  <= s_tdata[192 +: drr_pkg::SCALE_W];
				sticky_q <= 1'b0;
			end
			drr_pkg::ST_CHECK: begin
				cnt_q <= '0;
				rem_q <= drr_pkg::DIGIT_ZERO;
				if (emit) begin
					m_tdata_q <= {2'b00, scale_q, v_q[95:0]};
					m_tuser_q <= wide;
				end
			end
			drr_pkg::ST_DIV: begin
				v_q   <= {v_q[PAD_BITS-LIMB_W-1:0], q_limb};
				rem_q <= rem_next;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LIMBS - 1)) begin
					scale_q <= scale_q - 1'b1;
				end
			end
			drr_pkg::ST_ROUND: begin
				if (!wide) begin
					v_q <= v_q + PAD_BITS'(round_up);
				end
				if (rem_q != drr_pkg::DIGIT_ZERO) begin
					sticky_q <= 1'b1;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign s_tready = (state_q == drr_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: hdl/drr_checker.sv
module drr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [drr_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [drr_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic [drr_pkg::M_USER_W-1:0]  m_tuser
);

	// A result waiting for the receiver stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Reduction stops short of fitting only when the scale is used up.
	a_overflow_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[101:96] == '0)
		else $error("overflow with scale left");

	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken straight after the first");

	// No payload checks on the input side.
	logic unused_in;
	assign unused_in = ^s_tdata;

endmodule

bind decimal_rescale_round_half_even drr_checker u_drr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
